[rtl/sctu_pkg.sv]
// ----------------------------------------------------------------------------
// sctu_pkg
// Shared types, constants and coefficient table for the sine, cosine and
// tangent unit.
// ----------------------------------------------------------------------------
package sctu_pkg;

   // pi/2 in Q.32
   localparam logic [32:0] HP_Q32 = 33'd6746518852;

   // reciprocal of pi/2 scaled by 2^32, used for the quadrant estimate
   localparam logic [63:0] RECIP_WIDE = 64'hFFFF_FFFF_FFFF_FFFF / 64'd6746518852;
   localparam logic [31:0] RECIP_Q    = RECIP_WIDE[31:0];

   // highest coefficient index of the odd polynomial
   localparam int MAX_TERM = 10;

   // defaults for the top level parameters
   localparam int DEF_FULL_DEGREE = 17;
   localparam int DEF_FAST_DEGREE = 7;
   localparam int DEF_QUEUE_DEPTH = 4;

   // function selector codes
   typedef enum logic [1:0] {
      FUNC_SIN  = 2'd0,
      FUNC_COS  = 2'd1,
      FUNC_TAN  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   // classified request handed from the front to the back
   typedef struct packed {
      func_type    func;
      logic        neg;
      logic [1:0]  quad;
      logic [32:0] r;
      logic        mag_zero;
   } item_type;

   // signed Taylor coefficients (-1)^k / (2k+1)! in Q.60
   function automatic logic signed [63:0] coef(input logic [3:0] k);
      logic signed [63:0] c;
      unique case (k)
         4'd0:    c = 64'sd1152921504606846976;
         4'd1:    c = -64'sd192153584101141163;
         4'd2:    c = 64'sd9607679205057058;
         4'd3:    c = -64'sd228754266787073;
         4'd4:    c = 64'sd3177142594265;
         4'd5:    c = -64'sd28883114493;
         4'd6:    c = 64'sd185148170;
         4'd7:    c = -64'sd881658;
         4'd8:    c = 64'sd3241;
         4'd9:    c = -64'sd9;
         default: c = 64'sd0;
      endcase
      return c;
   endfunction

endpackage

[rtl/sctu_front.sv]
// ----------------------------------------------------------------------------
// sctu_front
// Takes requests, forms the angle magnitude and splits it into quadrant and
// residue modulo pi/2 in a pipeline, one request per cycle.
// ----------------------------------------------------------------------------
module sctu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            func,
   input  logic signed [47:0]    angle,
   output logic                  push,
   output sctu_pkg::item_type    push_item
);

   logic        v1_ff, v2_ff, v3_ff;
   logic [1:0]  func1_ff, func2_ff, func3_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [47:0] mag1_ff, mag2_ff;
   logic [63:0] prod2_ff;
   logic        zero3_ff;
   logic [15:0] qe3_ff;
   logic [33:0] r3_ff;

   logic [48:0] diff;
   logic        ge;
   logic [33:0] r_fix;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // raw residue from the estimated quotient
   assign diff = {1'b0, mag2_ff} - ({33'd0, prod2_ff[63:48]} * {16'd0, sctu_pkg::HP_Q32});

   // payload stages
   always_ff @(posedge clock) begin
      // stage 1: sign and magnitude
      func1_ff <= func;
      neg1_ff  <= angle[47];
      mag1_ff  <= angle[47] ? 48'(-angle) : 48'(angle);
      // stage 2: reciprocal product
      func2_ff <= func1_ff;
      neg2_ff  <= neg1_ff;
      mag2_ff  <= mag1_ff;
      prod2_ff <= {32'd0, mag1_ff[47:16]} * {32'd0, sctu_pkg::RECIP_Q};
      // stage 3: estimated quotient and residue
      func3_ff <= func2_ff;
      neg3_ff  <= neg2_ff;
      zero3_ff <= (mag2_ff == 48'd0);
      qe3_ff   <= prod2_ff[63:48];
      r3_ff    <= diff[33:0];
   end

   // one correction step: the estimate is low by at most one
   assign ge    = (r3_ff >= {1'b0, sctu_pkg::HP_Q32});
   assign r_fix = ge ? (r3_ff - {1'b0, sctu_pkg::HP_Q32}) : r3_ff;

   assign push               = v3_ff;
   assign push_item.func     = sctu_pkg::func_type'(func3_ff);
   assign push_item.neg      = neg3_ff;
   assign push_item.quad     = qe3_ff[1:0] + {1'b0, ge};
   assign push_item.r        = r_fix[32:0];
   assign push_item.mag_zero = zero3_ff;

endmodule

[rtl/sctu_queue.sv]
// ----------------------------------------------------------------------------
// sctu_queue
// Small first-in first-out queue of classified requests between the front
// and the back.
// ----------------------------------------------------------------------------
module sctu_queue #(
   parameter int DEPTH = sctu_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sctu_pkg::item_type    push_item,
   input  logic                  pop,
   output sctu_pkg::item_type    pop_item,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sctu_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   assign pop_item = slot_ff[rd_ff];
   assign empty    = (cnt_ff == '0);

endmodule

[rtl/sctu_mul.sv]
// ----------------------------------------------------------------------------
// sctu_mul
// Sequential Q.60 multiplier: four 32x32 partial products, rounded to
// nearest with ties away from zero.
// ----------------------------------------------------------------------------
module sctu_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] res
);

   logic         busy_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff;
   logic [63:0]  prod_ff;
   logic [1:0]   shift_ff;
   logic         pvld_ff;
   logic [127:0] acc_ff;
   logic         done_ff;
   logic signed [63:0] res_ff;

   logic [31:0]  a_half, b_half;
   logic [127:0] prod_wide;
   logic [63:0]  mag;

   // partial product operand select
   assign a_half    = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign b_half    = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
   assign prod_wide = {64'd0, prod_ff} << {shift_ff, 5'd0};
   assign mag       = {1'b0, acc_ff[122:60]};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         pvld_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            pvld_ff <= 1'b0;
         end else if (busy_ff) begin
            cnt_ff  <= cnt_ff + 1'b1;
            pvld_ff <= (cnt_ff <= 3'd3);
            if (cnt_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath; the accumulator starts at the rounding constant
   always_ff @(posedge clock) begin
      if (go) begin
         ua_ff  <= a[63] ? 64'(-a) : 64'(a);
         ub_ff  <= b[63] ? 64'(-b) : 64'(b);
         neg_ff <= a[63] ^ b[63];
         acc_ff <= 128'd1 << 59;
      end else if (busy_ff) begin
         prod_ff  <= {32'd0, a_half} * {32'd0, b_half};
         shift_ff <= 2'({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]});
         if (pvld_ff) begin
            acc_ff <= acc_ff + prod_wide;
         end
         if (cnt_ff == 3'd5) begin
            res_ff <= neg_ff ? -$signed(mag) : $signed(mag);
         end
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

[rtl/sctu_back.sv]
// ----------------------------------------------------------------------------
// sctu_back
// Evaluates both polynomials with the shared multiplier, picks sign and
// complement by quadrant and runs the tangent quotient by long division.
// ----------------------------------------------------------------------------
module sctu_back #(
   parameter int FULL_TOP = 8,
   parameter int FAST_TOP = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  precision_mode,
   input  logic                  empty,
   input  sctu_pkg::item_type    pop_item,
   output logic                  pop,
   output logic                  rsp_strobe,
   output logic [47:0]           rsp_value,
   output logic                  rsp_saturated
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_SQ, ST_STEP, ST_HORN, ST_FIN,
      ST_EVAL, ST_TAN, ST_DIV, ST_DONE
   } state_type;

   localparam logic [47:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] LIM_NEG = 48'h8000_0000_0000;

   state_type           state_ff, state_in;
   sctu_pkg::item_type  item_ff, item_in;
   logic [3:0]          top_ff, top_in;
   logic                phase_ff, phase_in;
   logic signed [63:0]  u_ff, u_in;
   logic signed [63:0]  u2_ff, u2_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic [3:0]          k_ff, k_in;
   logic signed [63:0]  s_ff, s_in;
   logic signed [63:0]  c_ff, c_in;
   logic [63:0]         n_ff, n_in;
   logic [63:0]         d_ff, d_in;
   logic                qneg_ff, qneg_in;
   logic                nneg_ff, nneg_in;
   logic [63:0]         rem_ff, rem_in;
   logic [48:0]         nsh_ff, nsh_in;
   logic [48:0]         quo_ff, quo_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                strobe_ff, strobe_in;
   logic [47:0]         value_ff, value_in;
   logic                sat_ff, sat_in;

   logic                mul_go, mul_done;
   logic signed [63:0]  mul_a, mul_b, mul_res;

   // working signals
   logic signed [63:0]  v_sel, nn, dd;
   logic [32:0]         r_cmp;
   logic [79:0]         dlim;
   logic [63:0]         t_rem;
   logic                t_ge;
   logic [49:0]         res_q;
   logic [47:0]         lim;

   sctu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .res   (mul_res)
   );

   // round Q.60 to Q.32, ties away from zero
   function automatic logic [47:0] to_q32(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] r;
      logic [63:0] rn;
      m  = v[63] ? 64'(-v) : 64'(v);
      r  = (m + 64'd134217728) >> 28;
      rn = v[63] ? (~r + 64'd1) : r;
      return rn[47:0];
   endfunction

   assign r_cmp = sctu_pkg::HP_Q32 - item_ff.r;
   assign dlim  = ({16'd0, d_ff} << 15) + {16'd0, d_ff};
   assign t_rem = {rem_ff[62:0], nsh_ff[48]};
   assign t_ge  = (t_rem >= d_ff);
   assign res_q = ({1'b0, quo_ff} + 50'd1) >> 1;
   assign lim   = qneg_ff ? LIM_NEG : LIM_POS;

   // quadrant selection of the sine or cosine term and tangent operands
   always_comb begin
      v_sel = '0;
      unique case (item_ff.func)
         sctu_pkg::FUNC_SIN: begin
            unique case (item_ff.quad)
               2'd0:    v_sel = s_ff;
               2'd1:    v_sel = c_ff;
               2'd2:    v_sel = -s_ff;
               default: v_sel = -c_ff;
            endcase
         end
         sctu_pkg::FUNC_COS: begin
            unique case (item_ff.quad)
               2'd0:    v_sel = c_ff;
               2'd1:    v_sel = -s_ff;
               2'd2:    v_sel = -c_ff;
               default: v_sel = s_ff;
            endcase
         end
         default: v_sel = '0;
      endcase
      nn = item_ff.quad[0] ? -c_ff : s_ff;
      dd = item_ff.quad[0] ? s_ff : c_ff;
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      top_in    = top_ff;
      phase_in  = phase_ff;
      u_in      = u_ff;
      u2_in     = u2_ff;
      acc_in    = acc_ff;
      k_in      = k_ff;
      s_in      = s_ff;
      c_in      = c_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      qneg_in   = qneg_ff;
      nneg_in   = nneg_ff;
      rem_in    = rem_ff;
      nsh_in    = nsh_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      value_in  = value_ff;
      sat_in    = sat_ff;
      pop       = 1'b0;
      mul_go    = 1'b0;
      mul_a     = u_ff;
      mul_b     = u_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               item_in  = pop_item;
               top_in   = precision_mode ? 4'(FULL_TOP) : 4'(FAST_TOP);
               phase_in = 1'b0;
               u_in     = {3'd0, pop_item.r, 28'd0};
               state_in = ST_START;
            end
         end
         // square the argument
         ST_START: begin
            mul_go   = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (mul_done) begin
               u2_in    = mul_res;
               acc_in   = sctu_pkg::coef(top_ff);
               k_in     = top_ff;
               state_in = ST_STEP;
            end
         end
         // Horner step or closing multiply by the argument
         ST_STEP: begin
            mul_go = 1'b1;
            mul_b  = acc_ff;
            if (k_ff != 4'd0) begin
               mul_a    = u2_ff;
               state_in = ST_HORN;
            end else begin
               mul_a    = u_ff;
               state_in = ST_FIN;
            end
         end
         ST_HORN: begin
            if (mul_done) begin
               acc_in   = sctu_pkg::coef(k_ff - 4'd1) + mul_res;
               k_in     = k_ff - 4'd1;
               state_in = ST_STEP;
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               if (!phase_ff) begin
                  s_in     = mul_res;
                  phase_in = 1'b1;
                  u_in     = {3'd0, r_cmp, 28'd0};
                  state_in = ST_START;
               end else begin
                  c_in     = mul_res;
                  state_in = ST_EVAL;
               end
            end
         end
         // sine, cosine and tangent operand setup
         ST_EVAL: begin
            unique case (item_ff.func)
               sctu_pkg::FUNC_SIN: begin
                  value_in  = to_q32(item_ff.neg ? -v_sel : v_sel);
                  sat_in    = 1'b0;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
               sctu_pkg::FUNC_COS: begin
                  value_in  = item_ff.mag_zero ? 48'h1_0000_0000 : to_q32(v_sel);
                  sat_in    = 1'b0;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
               sctu_pkg::FUNC_TAN: begin
                  n_in     = nn[63] ? 64'(-nn) : 64'(nn);
                  d_in     = dd[63] ? 64'(-dd) : 64'(dd);
                  nneg_in  = nn[63];
                  qneg_in  = (nn[63] ^ dd[63]) ^ item_ff.neg;
                  state_in = ST_TAN;
               end
               default: begin
                  value_in  = '0;
                  sat_in    = 1'b0;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            endcase
         end
         // zero divisor and overflow checks, else start division
         ST_TAN: begin
            priority if (d_ff == 64'd0) begin
               value_in  = (nneg_ff ^ item_ff.neg) ? LIM_NEG : LIM_POS;
               sat_in    = 1'b1;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if ({16'd0, n_ff} >= dlim) begin
               value_in  = lim;
               sat_in    = 1'b1;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rem_in   = n_ff >> 16;
               nsh_in   = {n_ff[15:0], 33'd0};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         // one quotient bit per cycle
         ST_DIV: begin
            rem_in = t_ge ? (t_rem - d_ff) : t_rem;
            quo_in = {quo_ff[47:0], t_ge};
            nsh_in = nsh_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) begin
               state_in = ST_DONE;
            end
         end
         // round quotient and clip
         ST_DONE: begin
            if (res_q > {2'd0, lim}) begin
               value_in = lim;
               sat_in   = 1'b1;
            end else begin
               value_in = qneg_ff ? 48'(-res_q) : res_q[47:0];
               sat_in   = 1'b0;
            end
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      item_ff  <= item_in;
      top_ff   <= top_in;
      phase_ff <= phase_in;
      u_ff     <= u_in;
      u2_ff    <= u2_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      qneg_ff  <= qneg_in;
      nneg_ff  <= nneg_in;
      rem_ff   <= rem_in;
      nsh_ff   <= nsh_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_value     = value_ff;
   assign rsp_saturated = sat_ff;

endmodule

[rtl/sine_cosine_tangent_unit_core.sv]
// ----------------------------------------------------------------------------
// sine_cosine_tangent_unit_core
// Sine, cosine and tangent of a signed Q16.32 angle by odd Taylor series.
// ----------------------------------------------------------------------------
// Usage:
//   a request (req_func, req_angle) is taken at a clock edge with start high
//   and busy low. The front reduces the angle modulo pi/2 in a pipeline, one
//   request per cycle while busy is low, into a queue of QUEUE_DEPTH entries.
//   busy rises only when the front and queue hold QUEUE_DEPTH requests.
//   The back evaluates both polynomials with one sequential 64x64 multiplier
//   (four 32x32 partial products, with its start and done handshake) and
//   runs long division for tangent; it takes the next request from the
//   queue only when it is through with the last one, so this multiplier and
//   the divider set the throughput. Each result shows on rsp_value and
//   rsp_saturated for one cycle with rsp_strobe high; the receiver cannot
//   stall it. The user must write csr_precision_mode with csr_valid only
//   while the unit is idle; the block itself does not enforce it.
//   csr_ready is always high. Reset empties the pipeline and queue and sets
//   precision_mode to the full degree.
// ----------------------------------------------------------------------------
module sine_cosine_tangent_unit_core #(
   parameter int FULL_DEGREE = sctu_pkg::DEF_FULL_DEGREE,
   parameter int FAST_DEGREE = sctu_pkg::DEF_FAST_DEGREE,
   parameter int QUEUE_DEPTH = sctu_pkg::DEF_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [47:0] req_angle,
   output logic               rsp_strobe,
   output logic signed [47:0] rsp_value,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_precision_mode
);

   localparam int FULL_RAW = (FULL_DEGREE - 1) / 2;
   localparam int FAST_RAW = (FAST_DEGREE - 1) / 2;
   localparam int FULL_TOP = (FULL_RAW > sctu_pkg::MAX_TERM) ? sctu_pkg::MAX_TERM : FULL_RAW;
   localparam int FAST_TOP = (FAST_RAW > sctu_pkg::MAX_TERM) ? sctu_pkg::MAX_TERM : FAST_RAW;
   localparam int CW       = $clog2(QUEUE_DEPTH + 1);

   logic               mode_ff;
   logic [CW-1:0]      credit_ff, credit_in;
   logic               accept;
   logic               push, pop, empty;
   sctu_pkg::item_type push_item, pop_item;
   logic [47:0]        value_raw;

   // request acceptance against free queue credits
   assign accept    = start & ~busy;
   assign busy      = (credit_ff == '0);
   assign csr_ready = 1'b1;

   always_comb begin
      unique case ({accept, pop})
         2'b10:   credit_in = credit_ff - 1'b1;
         2'b01:   credit_in = credit_ff + 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   // credits and precision mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= CW'(QUEUE_DEPTH);
         mode_ff   <= 1'b1;
      end else begin
         credit_ff <= credit_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_precision_mode;
         end
      end
   end

   sctu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .angle     (req_angle),
      .push      (push),
      .push_item (push_item)
   );

   sctu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   sctu_back #(
      .FULL_TOP (FULL_TOP),
      .FAST_TOP (FAST_TOP)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .precision_mode (mode_ff),
      .empty          (empty),
      .pop_item       (pop_item),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_value      (value_raw),
      .rsp_saturated  (rsp_saturated)
   );

   assign rsp_value = $signed(value_raw);

endmodule

[dv/tb_sine_cosine_tangent_unit_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_tangent_unit_core
// Self-checking bench for the sine, cosine and tangent unit. Requests go in
// through the start/busy handshake with random gaps. A bit-exact fixed-point
// predictor computes the value and the saturation flag of each request, and
// a scoreboard checks each strobed response in order against it.
// ----------------------------------------------------------------------------
module tb_sine_cosine_tangent_unit_core;

   localparam logic [63:0] PI_HALF = 64'd6746518852;
   localparam int IDLE_LIMIT = 20000;

   // expected response of one request
   typedef struct {
      logic [47:0] value;
      logic        sat;
   } trig_result_type;

   // Q.60 coefficients (-1)^k/(2k+1)!
   function automatic longint taylor_coef(input int k);
      longint t[11] = '{64'sd1152921504606846976, -64'sd192153584101141163,
         64'sd9607679205057058, -64'sd228754266787073, 64'sd3177142594265,
         -64'sd28883114493, 64'sd185148170, -64'sd881658, 64'sd3241, -64'sd9, 0};
      return t[k];
   endfunction

   // product in Q.60 rounded to nearest, ties away from zero
   function automatic longint mul_q60(input longint a, input longint b);
      logic [63:0] ua, ub, res;
      logic [127:0] p;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p + (128'd1 << 59);
      res = p[123:60];
      res[63] = 1'b0;
      return ((a < 0) != (b < 0)) ? -longint'(res) : longint'(res);
   endfunction

   // odd Taylor polynomial by horner's rule
   function automatic longint taylor_poly(input logic [63:0] u32, input int top);
      longint u, u2, acc;
      u = longint'(u32 << 28);
      u2 = mul_q60(u, u);
      acc = taylor_coef(top);
      for (int k = top; k > 0; k--) acc = taylor_coef(k - 1) + mul_q60(u2, acc);
      return mul_q60(u, acc);
   endfunction

   function automatic longint round_q32(input longint v);
      logic [63:0] m;
      m = ((v < 0 ? -v : v) + (64'd1 << 27)) >> 28;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic trig_result_type predict_trig(input logic [1:0] fn,
                                                    input logic [47:0] ang,
                                                    input logic fullmode);
      trig_result_type o;
      logic neg, qneg;
      logic [63:0] mag, q, r, n, d, lim, res, iq, rem, f;
      logic [1:0] quad;
      int top;
      longint s, c, v, nn, dd, value;
      neg = ang[47];
      mag = neg ? (64'd1 << 48) - {16'd0, ang} : {16'd0, ang};
      q = mag / PI_HALF;
      r = mag - q * PI_HALF;
      quad = q[1:0];
      top = fullmode ? (sctu_pkg::DEF_FULL_DEGREE - 1) / 2
                     : (sctu_pkg::DEF_FAST_DEGREE - 1) / 2;
      if (top > sctu_pkg::MAX_TERM) top = sctu_pkg::MAX_TERM;
      s = taylor_poly(r, top);
      c = taylor_poly(PI_HALF - r, top);
      value = 0;
      o.sat = 1'b0;
      case (fn)
         sctu_pkg::FUNC_SIN: begin
            v = quad == 0 ? s : quad == 1 ? c : quad == 2 ? -s : -c;
            value = round_q32(neg ? -v : v);
         end
         sctu_pkg::FUNC_COS: begin
            if (mag == 0) value = 64'sd1 << 32;
            else begin
               v = quad == 0 ? c : quad == 1 ? -s : quad == 2 ? -c : s;
               value = round_q32(v);
            end
         end
         sctu_pkg::FUNC_TAN: begin
            nn = quad[0] ? -c : s;
            dd = quad[0] ? s : c;
            qneg = ((nn < 0) != (dd < 0)) != neg;
            n = nn < 0 ? -nn : nn;
            d = dd < 0 ? -dd : dd;
            if (d == 0) begin
               qneg = (nn < 0) != neg;
               res = qneg ? (64'd1 << 47) : (64'd1 << 47) - 1;
               o.sat = 1'b1;
            end else begin
               lim = qneg ? (64'd1 << 47) : (64'd1 << 47) - 1;
               iq = n / d;
               rem = n % d;
               f = 0;
               if (iq > (64'd1 << 15)) begin
                  res = lim;
                  o.sat = 1'b1;
               end else begin
                  for (int i = 0; i < 33; i++) begin
                     rem = rem << 1;
                     f = f << 1;
                     if (rem >= d) begin
                        rem = rem - d;
                        f[0] = 1'b1;
                     end
                  end
                  res = (iq << 32) + ((f + 1) >> 1);
                  if (res > lim) begin
                     res = lim;
                     o.sat = 1'b1;
                  end
               end
            end
            value = qneg ? -longint'(res) : longint'(res);
         end
         default: value = 0;
      endcase
      o.value = value[47:0];
      return o;
   endfunction

   // in-order store of expected responses
   class trig_scoreboard;
      trig_result_type pending[$];
      int errors = 0;

      function void note_request(logic [1:0] fn, logic [47:0] ang, logic fullmode);
         pending.push_back(predict_trig(fn, ang, fullmode));
      endfunction

      function void check_response(logic [47:0] value, logic sat);
         trig_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response value=%h sat=%b", $time, value, sat);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) begin
            $display("%0t: value expected %h actual %h", $time, e.value, value);
            errors++;
         end
         if (sat !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_func = '0;
   logic signed [47:0] req_angle = '0;
   logic rsp_strobe;
   logic signed [47:0] rsp_value;
   logic rsp_saturated;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_precision_mode = 0;

   trig_scoreboard board = new();
   logic mode_now = 1'b1;
   int idle_pct = 0;
   int idle_cycles = 0;

   sine_cosine_tangent_unit_core DUT (.*);

   always #5 clock = ~clock;

   // accepted requests and responses, with the stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_request(req_func, req_angle, mode_now);
         if (rsp_strobe) board.check_response(rsp_value, rsp_saturated);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // one request, with a random gap before it; start stays high afterwards
   task automatic send_request(input logic [1:0] fn, input logic [47:0] ang);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= fn;
      req_angle <= ang;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // wait out every pending response, then let the pipeline settle
   task automatic drain_unit();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_valid <= 1'b1;
      csr_precision_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode_now = m;
   endtask

   function automatic logic [47:0] random_angle();
      logic [47:0] a;
      logic [63:0] k;
      a = {$urandom, $urandom};
      case ($urandom_range(4))
         0: a = a;
         1: a = 48'($signed({1'b0, a[34:0]}) * ($urandom_range(1) ? 1 : -1));
         2: begin
            // near a multiple of pi/2
            k = $urandom_range(30);
            a = 48'(k * PI_HALF + 64'($signed(4'($urandom))));
            if ($urandom_range(1)) a = -a;
         end
         default: a = 48'($signed(a[39:0]));
      endcase
      return a;
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) idle_pct = (i / 50) % 4 == 1 ? 71 : (i / 50) % 4 == 3 ? 22 : 0;
         send_request(2'($urandom_range(99) < 3 ? 3 : $urandom_range(2)), random_angle());
      end
   endtask

   initial begin
      logic [47:0] dir[$];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, range extremes, exact multiples of pi/2, near them
      dir = '{48'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'd1,
              48'(PI_HALF), 48'(2 * PI_HALF), 48'(3 * PI_HALF), 48'(PI_HALF - 1),
              48'(-PI_HALF), 48'(-3 * PI_HALF), 48'(5 * PI_HALF + 1)};
      foreach (dir[i]) begin
         send_request(sctu_pkg::FUNC_SIN, dir[i]);
         send_request(sctu_pkg::FUNC_COS, dir[i]);
         if (i < 10) send_request(sctu_pkg::FUNC_TAN, dir[i]);
      end
      send_request(sctu_pkg::FUNC_NONE, 48'h1234_5678_9ABC);
      drain_unit();

      random_phase(250);
      drain_unit();
      write_mode(1'b0);
      random_phase(250);
      drain_unit();
      write_mode(1'b1);
      random_phase(150);
      drain_unit();
      write_mode(1'b0);
      random_phase(150);
      drain_unit();

      if (board.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

[sim.f]
rtl/sctu_pkg.sv
rtl/sctu_front.sv
rtl/sctu_queue.sv
rtl/sctu_mul.sv
rtl/sctu_back.sv
rtl/sine_cosine_tangent_unit_core.sv
dv/tb_sine_cosine_tangent_unit_core.sv
